@@ hw/rtl/pascal_line_classifier_defines.svh @@
// Assertion macros used by the port-level checker file of pascal_line_classifier.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef PASCAL_LINE_CLASSIFIER_DEFINES_SVH
`define PASCAL_LINE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PCL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pascal_line_classifier: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define PCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pascal_line_classifier: next-cycle check failed");

`endif

@@ hw/rtl/pcl_pkg.sv @@
// Package for pascal_line_classifier: payload structs, class codes, char constants.
// No dependencies.
package pcl_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_W     = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [2:0] {
    CLS_BLANK   = 3'd0,
    CLS_CODE    = 3'd1,
    CLS_COMMENT = 3'd2,
    CLS_BOTH    = 3'd3,
    CLS_NONE    = 3'd4
  } line_class_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         line_class;
    logic [TOTAL_W-1:0] total_lines;
    logic [TOTAL_W-1:0] code_lines;
    logic [TOTAL_W-1:0] comment_lines;
    logic [TOTAL_W-1:0] blank_lines;
  } out_item_t;

  // One item leaving the input register toward the line tracker.
  typedef struct packed {
    logic       fire;
    logic       eol;
    logic [7:0] char_code;
  } pcl_step_t;

  function automatic logic is_blank_byte(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic count_t sat_inc(input count_t v, input logic en);
    if (en && (v != '1)) return v + count_t'(1);
    return v;
  endfunction

endpackage

@@ hw/rtl/pcl_line_track.sv @@
// Per-line tracking and classification for pascal_line_classifier.
// Depends on pcl_pkg.
module pcl_line_track import pcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pcl_step_t   step,
  output line_class_t line_class
);

  logic       in_brace_r,   in_brace_nxt;
  logic [1:0] nonspace_r,   nonspace_nxt;
  logic [7:0] first_r,      first_nxt;
  logic [7:0] second_r,     second_nxt;
  logic [7:0] last_r,       last_nxt;
  logic       open_r,       open_nxt;
  logic       close_r,      close_nxt;
  logic       dslash_r,     dslash_nxt;
  logic       prev_slash_r, prev_slash_nxt;

  logic        f;
  logic        brace_set;
  logic        brace_clr;
  line_class_t cls;

  // Rule order at line end
  always_comb begin
    f         = in_brace_r;
    brace_set = 1'b0;
    brace_clr = 1'b0;
    if (nonspace_r == 2'd0) begin
      cls = CLS_BLANK;
    end else if (!f && first_r == CH_LBRACE && last_r == CH_RBRACE) begin
      cls = CLS_COMMENT;
    end else if (!f && open_r && close_r) begin
      cls = CLS_BOTH;
    end else if (!f && nonspace_r == 2'd2 && first_r == CH_SLASH && second_r == CH_SLASH) begin
      cls = CLS_COMMENT;
    end else if (!f && dslash_r) begin
      cls = CLS_BOTH;
    end else if (!f && first_r == CH_LBRACE) begin
      brace_set = 1'b1;
      cls       = CLS_COMMENT;
    end else if (f) begin
      brace_clr = (last_r == CH_RBRACE);
      cls       = CLS_COMMENT;
    end else if (!dslash_r && !open_r && !close_r) begin
      cls = CLS_CODE;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign line_class = cls;

  always_comb begin
    in_brace_nxt   = in_brace_r;
    nonspace_nxt   = nonspace_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    last_nxt       = last_r;
    open_nxt       = open_r;
    close_nxt      = close_r;
    dslash_nxt     = dslash_r;
    prev_slash_nxt = prev_slash_r;
    if (step.fire && step.eol) begin
      if (brace_set) in_brace_nxt = 1'b1;
      if (brace_clr) in_brace_nxt = 1'b0;
      nonspace_nxt   = 2'd0;
      open_nxt       = 1'b0;
      close_nxt      = 1'b0;
      dslash_nxt     = 1'b0;
      prev_slash_nxt = 1'b0;
    end else if (step.fire) begin
      if (is_blank_byte(step.char_code)) begin
        if (nonspace_r == 2'd1) begin
          second_nxt   = step.char_code;
          nonspace_nxt = 2'd2;
        end
        prev_slash_nxt = 1'b0;
      end else begin
        if (nonspace_r == 2'd0) begin
          first_nxt    = step.char_code;
          nonspace_nxt = 2'd1;
        end else if (nonspace_r == 2'd1) begin
          second_nxt   = step.char_code;
          nonspace_nxt = 2'd2;
        end
        last_nxt = step.char_code;
        if (step.char_code == CH_LBRACE) open_nxt  = 1'b1;
        if (step.char_code == CH_RBRACE) close_nxt = 1'b1;
        if (step.char_code == CH_SLASH && prev_slash_r) dslash_nxt = 1'b1;
        prev_slash_nxt = (step.char_code == CH_SLASH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_brace_r   <= 1'b0;
      nonspace_r   <= 2'd0;
      open_r       <= 1'b0;
      close_r      <= 1'b0;
      dslash_r     <= 1'b0;
      prev_slash_r <= 1'b0;
    end else begin
      in_brace_r   <= in_brace_nxt;
      nonspace_r   <= nonspace_nxt;
      open_r       <= open_nxt;
      close_r      <= close_nxt;
      dslash_r     <= dslash_nxt;
      prev_slash_r <= prev_slash_nxt;
    end
  end

  // Character payload: only read once nonspace_r says it was loaded
  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    last_r   <= last_nxt;
  end

endmodule

@@ hw/rtl/pascal_line_classifier.sv @@
// Top level of pascal_line_classifier: input register, line tracker, totals, output register.
// Depends on pcl_pkg and pcl_line_track.
//
//  channel | signals                        | transfer carries
//  --------+--------------------------------+----------------------------------
//  in      | in_valid, in_ready, in_data    | one text byte or a line end
//  out     | out_valid, out_ready, out_data | line class plus four running totals
//
// One item per cycle sustained while no line end is held up. A byte or line end
// waits in the input register, then updates the line state; a line end also loads
// the output register at that same edge.
// Synchronous active-low reset clears the brace flag, line state and totals.
// A line end stalls in the input register only while a result waits unread;
// text bytes never wait on the output side.
module pascal_line_classifier import pcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Input register
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_data_r;
  logic     s1_go;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  // Running totals: total, code, comment, blank
  count_t total_r,   total_nxt;
  count_t code_r,    code_nxt;
  count_t comment_r, comment_nxt;
  count_t blank_r,   blank_nxt;

  pcl_step_t   step;
  line_class_t cls;
  logic        close_line;

  // A line end moves on only when the output register can take its result.
  assign s1_go      = s1_valid_r && (!s1_data_r.end_of_line || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_go;
  assign close_line = s1_go && s1_data_r.end_of_line;

  assign step.fire      = s1_go;
  assign step.eol       = s1_data_r.end_of_line;
  assign step.char_code = s1_data_r.char_code;

  pcl_line_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .line_class (cls)
  );

  always_comb begin
    total_nxt   = sat_inc(total_r,   close_line);
    code_nxt    = sat_inc(code_r,    close_line && (cls == CLS_CODE || cls == CLS_BOTH));
    comment_nxt = sat_inc(comment_r, close_line && (cls == CLS_COMMENT || cls == CLS_BOTH));
    blank_nxt   = sat_inc(blank_r,   close_line && (cls == CLS_BLANK));
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (close_line) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.line_class    = cls;
      out_data_nxt.total_lines   = TOTAL_W'(total_nxt);
      out_data_nxt.code_lines    = TOTAL_W'(code_nxt);
      out_data_nxt.comment_lines = TOTAL_W'(comment_nxt);
      out_data_nxt.blank_lines   = TOTAL_W'(blank_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      code_r      <= '0;
      comment_r   <= '0;
      blank_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      code_r      <= code_nxt;
      comment_r   <= comment_nxt;
      blank_r     <= blank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/pcl_checker.sv @@
// Port-level checker for pascal_line_classifier, bound to the top level.
// Depends on pcl_pkg and pascal_line_classifier_defines.svh.
`include "pascal_line_classifier_defines.svh"

module pcl_checker import pcl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic               seen_r;
  logic [TOTAL_W-1:0] last_total_r;
  logic               out_xfer;
  logic               counts_ok;
  logic               total_ok;

  assign out_xfer = out_valid && out_ready;

  // Per-class totals never pass the line total
  assign counts_ok = (out_data.code_lines <= out_data.total_lines) &&
                     (out_data.comment_lines <= out_data.total_lines) &&
                     (out_data.blank_lines <= out_data.total_lines);

  // Total rises by one per result, or holds once saturated
  assign total_ok = (out_data.total_lines == TOTAL_W'(last_total_r + TOTAL_W'(1))) ||
                    (out_data.total_lines == last_total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_xfer) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) last_total_r <= out_data.total_lines;
  end

  `PCL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))
  `PCL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `PCL_ASSERT_IMPLY(a_class_legal, out_valid, out_data.line_class <= CLS_NONE)
  `PCL_ASSERT_IMPLY(a_counts_bounded, out_valid, counts_ok)
  `PCL_ASSERT_IMPLY(a_total_steps, out_xfer && seen_r, total_ok)

endmodule

bind pascal_line_classifier pcl_checker u_pcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/pcl_tally_checker.sv @@
// Line result checker for pascal_line_classifier: watches both channels, keeps its own
// line state and totals, and compares every result transfer. Depends on pcl_pkg.
`timescale 1ns / 100ps

module pcl_tally_checker import pcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int REPORT_LIMIT = 10;

  // Predicted line state
  logic       brace_open;
  logic [1:0] seen_cnt;
  logic [7:0] first_ch;
  logic [7:0] second_ch;
  logic [7:0] last_ch;
  logic       saw_lbrace;
  logic       saw_rbrace;
  logic       saw_slashes;
  logic       prev_slash;
  count_t     totals [4];   // total, code, comment, blank

  out_item_t  tally_q [$];
  int         fails = 0;

  task automatic clear_line_state();
    seen_cnt    = 2'd0;
    first_ch    = 8'h00;
    second_ch   = 8'h00;
    last_ch     = 8'h00;
    saw_lbrace  = 1'b0;
    saw_rbrace  = 1'b0;
    saw_slashes = 1'b0;
    prev_slash  = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    out_item_t   want;
    line_class_t cls;
    logic [3:0]  bump;
    logic [7:0]  c;
    if (!rst_n) begin
      brace_open = 1'b0;
      clear_line_state();
      for (int k = 0; k < 4; k++) totals[k] = '0;
      tally_q.delete();
    end else begin
      // results first: the oldest expectation is always ahead of this edge's input
      if (out_valid && out_ready) begin
        if (tally_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: class %0d total %0d", $realtime,
                     out_data.line_class, out_data.total_lines);
        end else begin
          want = tally_q.pop_front();
          if (out_data.line_class    !== want.line_class    ||
              out_data.total_lines   !== want.total_lines   ||
              out_data.code_lines    !== want.code_lines    ||
              out_data.comment_lines !== want.comment_lines ||
              out_data.blank_lines   !== want.blank_lines) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $write("%0t: line result mismatch (exp/got): class %0d/%0d total %0d/%0d",
                     $realtime, want.line_class, out_data.line_class,
                     want.total_lines, out_data.total_lines);
              $display(" code %0d/%0d comment %0d/%0d blank %0d/%0d",
                       want.code_lines, out_data.code_lines,
                       want.comment_lines, out_data.comment_lines,
                       want.blank_lines, out_data.blank_lines);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        c = in_data.char_code;
        if (!in_data.end_of_line) begin
          if (c inside {8'h20, 8'h09, [8'h0A:8'h0D]}) begin
            // whitespace right after the first char still counts as the second char
            if (seen_cnt == 2'd1) begin
              second_ch = c;
              seen_cnt  = 2'd2;
            end
            prev_slash = 1'b0;
          end else begin
            if (seen_cnt == 2'd0) begin
              first_ch = c;
              seen_cnt = 2'd1;
            end else if (seen_cnt == 2'd1) begin
              second_ch = c;
              seen_cnt  = 2'd2;
            end
            last_ch = c;
            if (c == CH_LBRACE) saw_lbrace = 1'b1;
            if (c == CH_RBRACE) saw_rbrace = 1'b1;
            if (c == CH_SLASH && prev_slash) saw_slashes = 1'b1;
            prev_slash = (c == CH_SLASH);
          end
        end else begin
          if (seen_cnt == 2'd0)
            cls = CLS_BLANK;
          else if (!brace_open && first_ch == CH_LBRACE && last_ch == CH_RBRACE)
            cls = CLS_COMMENT;
          else if (!brace_open && saw_lbrace && saw_rbrace)
            cls = CLS_BOTH;
          else if (!brace_open && seen_cnt == 2'd2 && first_ch == CH_SLASH &&
                   second_ch == CH_SLASH)
            cls = CLS_COMMENT;
          else if (!brace_open && saw_slashes)
            cls = CLS_BOTH;
          else if (!brace_open && first_ch == CH_LBRACE) begin
            brace_open = 1'b1;
            cls        = CLS_COMMENT;
          end else if (brace_open) begin
            if (last_ch == CH_RBRACE) brace_open = 1'b0;
            cls = CLS_COMMENT;
          end else if (!saw_slashes && !saw_lbrace && !saw_rbrace)
            cls = CLS_CODE;
          else
            cls = CLS_NONE;

          bump = {cls == CLS_BLANK, cls == CLS_COMMENT || cls == CLS_BOTH,
                  cls == CLS_CODE || cls == CLS_BOTH, 1'b1};
          for (int k = 0; k < 4; k++)
            if (bump[k] && totals[k] != '1) totals[k] = totals[k] + 1'b1;

          want.line_class    = cls;
          want.total_lines   = TOTAL_W'(totals[0]);
          want.code_lines    = TOTAL_W'(totals[1]);
          want.comment_lines = TOTAL_W'(totals[2]);
          want.blank_lines   = TOTAL_W'(totals[3]);
          tally_q.push_back(want);
          clear_line_state();
        end
      end
    end
    pending    <= tally_q.size();
    fail_count <= fails;
  end

endmodule

@@ test/pascal_line_classifier_test.sv @@
// Top of the pascal_line_classifier test: clock, reset, text stimulus, result sink, verdict.
// Depends on pcl_pkg, pascal_line_classifier and pcl_tally_checker.
`timescale 1ns / 100ps

module pascal_line_classifier_test;
  import pcl_pkg::*;

  localparam int ITEM_TARGET   = 1050;    // text bytes plus line ends
  localparam int MAX_GAP       = 17;      // per-transfer idle draw, both sides
  localparam int HOLD_AFTER    = 60;      // results taken before the long hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;       // extra wait after a drain for a stray result
  localparam int CYCLE_LIMIT   = 400000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;       // results predicted but not yet seen
  int bytes_sent  = 0;
  int lines_sent  = 0;
  int send_burst  = 0;   // transfers left in a no-idle stretch on the input side

  pascal_line_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Watches both channels and owns all prediction and comparison.
  pcl_tally_checker tally_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One input transfer. Called at a rising edge; returns at the edge where the
  // item was taken. valid is only lowered when a gap follows, so a back-to-back
  // item never sees valid dropped and raised in the same step.
  task automatic send_item(input in_item_t item);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.end_of_line) lines_sent++;
    else bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item('{char_code: c, end_of_line: 1'b0});
  endtask

  // char_code is don't-care on a line end; randomize it anyway
  task automatic send_eol();
    send_item('{char_code: 8'($urandom), end_of_line: 1'b1});
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_eol();
  endtask

  // Park the input and wait until every predicted result has been taken,
  // then waits out the settle time in case a stray result is still on its way.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // Text byte skewed toward the characters the classifier cares about.
  function automatic logic [7:0] pick_text_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2)  return CH_LBRACE;
    if (r < 4)  return CH_RBRACE;
    if (r < 7)  return CH_SLASH;
    if (r < 9)  return pick_space();
    if (r < 11) return 8'($urandom);
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  // Input side: reset, directed lines, then random lines.
  initial begin : stimulus
    int  shape;
    bit  mid_drained;
    mid_drained = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: at least one line per classifier rule.
    send_eol();             // empty line: blank
    send_line("{}");        // opens with brace, ends with brace: comment
    send_line("a{}");       // both braces after code: code and comment
    send_line("//");        // slash pair at start: comment
    send_line("a//");       // slash pair after code: code and comment
    send_line("{");         // unclosed brace comment carries to next line
    send_line("a");         // inside brace comment, no close: comment
    send_line("}");         // inside brace comment, closes it
    send_line("/ /");       // split slashes, second char is whitespace: code
    send_line("a}");        // stray close brace: uncounted
    send_byte(8'h00);       // byte extremes are ordinary chars: code
    send_byte(8'hFF);
    send_eol();
    wait_for_drain();

    // Random: mostly Pascal-shaped lines with random content, some noise.
    while (bytes_sent + lines_sent < ITEM_TARGET) begin
      shape = $urandom_range(0, 9);
      repeat ($urandom_range(0, 2)) send_byte(pick_space());
      case (shape)
        0, 1: begin
          send_byte(CH_SLASH);
          send_byte(CH_SLASH);
        end
        2, 3, 4: send_byte(CH_LBRACE);
        default: ;
      endcase
      repeat ($urandom_range(0, 8)) send_byte(pick_text_char());
      if (shape == 3 || shape == 5 || (shape == 4 && $urandom_range(0, 1) == 1))
        send_byte(CH_RBRACE);
      send_eol();
      // one full stop halfway through, sender idle until the sink has caught up
      if (!mid_drained && bytes_sent + lines_sent >= ITEM_TARGET / 2) begin
        mid_drained = 1'b1;
        wait_for_drain();
      end
    end

    wait_for_drain();
    $display("Covered %0d text bytes and %0d line ends, every line class and brace carry-over,",
             bytes_sent, lines_sent);
    $display("with random idling on both sides, one long sink hold-off and three full drains.");
    if (fail_count == 0 && pending == 0)
      $display("pascal_line_classifier_test passed");
    else
      $display("pascal_line_classifier_test failed");
    $finish;
  end

  // Result side: random stalls, no-stall stretches, and one long hold-off
  // while the sender keeps offering so a line end backs up the input.
  initial begin : sink
    int stall;
    int taken;
    int burst;
    bit held;
    taken = 0;
    burst = 0;
    held  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (burst > 0) begin
        burst--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 29) == 0) burst = $urandom_range(15, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pascal_line_classifier_test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_line_track.sv
hw/rtl/pascal_line_classifier.sv
hw/rtl/pcl_checker.sv
test/pcl_tally_checker.sv
test/pascal_line_classifier_test.sv
